// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers shared by the framer modules
// every user has clk_i and rst_ni (active low) in scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gzf_pkg.sv =====
// ----------------------------------------------------------------------------
// gzf_pkg
// shared types, codes and byte tables of the gzip stored-block framer
// ----------------------------------------------------------------------------
`default_nettype none

package gzf_pkg;

  localparam int unsigned LEN_W       = 31;
  localparam int unsigned CRC_W       = 32;
  localparam int unsigned RUN_W       = 16;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(32'h4000_0000);
  localparam logic [CRC_W-1:0] CRC_POLY    = 32'hedb8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT    = 32'hffff_ffff;
  localparam logic [RUN_W-1:0] RUN_MAX     = 16'hffff;

  // command codes
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_CHUNK  = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_SEQ   = 2'd2;

  // kinds of work handed from front to back
  typedef enum logic [2:0] {
    JOB_HEAD,
    JOB_BLOCK,
    JOB_DATA,
    JOB_FINISH,
    JOB_ERROR
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [1:0]       status;
    logic [7:0]       dbyte;
    logic [RUN_W-1:0] run;
    logic [CRC_W-1:0] crc;
    logic [LEN_W-1:0] total;
  } job_t;

  // fixed byte sequences
  localparam logic [7:0] GZ_HEAD [10] = '{
    8'd31, 8'd139, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255
  };
  localparam logic [7:0] FINAL_BLOCK [5] = '{8'd1, 8'd0, 8'd0, 8'd255, 8'd255};

  // index of the final output byte of each job kind
  function automatic logic [IDX_W-1:0] job_last_idx(input job_kind_e kind);
    logic [IDX_W-1:0] r;
    unique case (kind)
      JOB_HEAD:   r = IDX_W'(9);
      JOB_BLOCK:  r = IDX_W'(5);
      JOB_FINISH: r = IDX_W'(12);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/gzip_stored_block_framer.sv =====
// ----------------------------------------------------------------------------
// gzip_stored_block_framer
// Turns start / chunk / data / finish commands into a gzip stream of stored
// deflate blocks, with crc-32 and isize trailer. A data byte inside a running
// block gives one output byte; bytes flow at one per cycle while the queue has
// room. Start gives 10 output bytes, the first byte of each run of up to 65535
// bytes gives 6 (block header plus the byte), finish gives 13, any error one,
// a chunk announcement none. Output bytes leave at one per cycle from the back
// end unless the receiver stalls; the input side is held off only when the
// QueueDepth-entry job queue between front and back is full (range 2 and up).
// ----------------------------------------------------------------------------
`default_nettype none

module gzip_stored_block_framer import gzf_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [LEN_W-1:0] chunk_length_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  logic q_full, q_valid, push, pop;
  job_t push_job, head_job;

  // command front
  gzf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .chunk_length_i (chunk_length_i),
    .data_byte_i    (data_byte_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // job queue
  gzf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (head_job)
  );

  // byte back end
  gzf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== design/gzf_front.sv =====
// ----------------------------------------------------------------------------
// gzf_front
// accepts commands, tracks stream state and crc, pushes one job per result run
// ----------------------------------------------------------------------------
`default_nettype none

module gzf_front import gzf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       action_i,
  input  logic [LEN_W-1:0] chunk_length_i,
  input  logic [7:0]       data_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output job_t             job_o
);

  logic             failed_q, failed_d;
  logic             in_stream_q, in_stream_d;
  logic [CRC_W-1:0] crc_q, crc_d;
  logic [LEN_W-1:0] total_q, total_d;
  logic [LEN_W-1:0] chunk_left_q, chunk_left_d;
  logic [RUN_W-1:0] block_left_q, block_left_d;
  logic [LEN_W-1:0] limit_q;
  logic             accept;
  logic             over_limit;
  logic [RUN_W-1:0] run;

  // one byte through the reflected crc
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                               input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // limit check and run length of a new block
  assign over_limit = (chunk_length_i > limit_q) || (total_q > (limit_q - chunk_length_i));
  assign run        = (chunk_left_q > LEN_W'(RUN_MAX)) ? RUN_MAX : chunk_left_q[RUN_W-1:0];

  // command decode
  always_comb begin
    failed_d     = failed_q;
    in_stream_d  = in_stream_q;
    crc_d        = crc_q;
    total_d      = total_q;
    chunk_left_d = chunk_left_q;
    block_left_d = block_left_q;
    push_o       = 1'b0;
    job_o.kind   = JOB_ERROR;
    job_o.status = ST_SEQ;
    job_o.dbyte  = data_byte_i;
    job_o.run    = run;
    job_o.crc    = ~crc_q;
    job_o.total  = total_q;
    if (accept) begin
      push_o = 1'b1;
      if (failed_q) begin
        job_o.kind = JOB_ERROR;
      end else begin
        unique case (action_e'(action_i))
          ACT_START: begin
            if (in_stream_q) begin
              failed_d = 1'b1;
            end else begin
              job_o.kind   = JOB_HEAD;
              crc_d        = CRC_INIT;
              total_d      = '0;
              chunk_left_d = '0;
              block_left_d = '0;
              in_stream_d  = 1'b1;
            end
          end
          ACT_CHUNK: begin
            if (!in_stream_q || chunk_left_q != '0) begin
              failed_d = 1'b1;
            end else if (over_limit) begin
              failed_d     = 1'b1;
              job_o.status = ST_LIMIT;
            end else begin
              push_o       = 1'b0;
              chunk_left_d = chunk_length_i;
              total_d      = total_q + chunk_length_i;
              block_left_d = '0;
            end
          end
          ACT_DATA: begin
            if (!in_stream_q || chunk_left_q == '0) begin
              failed_d = 1'b1;
            end else begin
              if (block_left_q == '0) begin
                job_o.kind   = JOB_BLOCK;
                block_left_d = run - 1'b1;
              end else begin
                job_o.kind   = JOB_DATA;
                block_left_d = block_left_q - 1'b1;
              end
              chunk_left_d = chunk_left_q - 1'b1;
              crc_d        = crc_byte(crc_q, data_byte_i);
            end
          end
          ACT_FINISH: begin
            if (!in_stream_q || chunk_left_q != '0) begin
              failed_d = 1'b1;
            end else begin
              job_o.kind  = JOB_FINISH;
              in_stream_d = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q     <= 1'b0;
      in_stream_q  <= 1'b0;
      crc_q        <= CRC_INIT;
      total_q      <= '0;
      chunk_left_q <= '0;
      block_left_q <= '0;
    end else begin
      failed_q     <= failed_d;
      in_stream_q  <= in_stream_d;
      crc_q        <= crc_d;
      total_q      <= total_d;
      chunk_left_q <= chunk_left_d;
      block_left_q <= block_left_d;
    end
  end

  // size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/gzf_queue.sv =====
// ----------------------------------------------------------------------------
// gzf_queue
// small job fifo between the command front and the byte back end
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gzf_queue import gzf_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t job_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_no_overflow, full_o, !push_i, "item pushed into full queue")
  `ASSERT_IMPL(a_no_underflow, !valid_o, !pop_i, "pop from empty queue")
  `ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "fill level lost")

endmodule

`default_nettype wire

// ===== design/gzf_back.sv =====
// ----------------------------------------------------------------------------
// gzf_back
// expands queued jobs into output bytes, one a cycle unless stalled, via an output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gzf_back import gzf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic [1:0]       out_status_q;
  logic             out_last_q;
  logic             load;
  logic             is_last;
  logic [7:0]       byte_sel;
  logic [1:0]       status_sel;

  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == job_last_idx(job_i.kind));
  assign pop_o   = load && is_last;

  // byte of the current job at the current index
  always_comb begin
    byte_sel   = 8'd0;
    status_sel = ST_OK;
    case (job_i.kind)
      JOB_HEAD: byte_sel = GZ_HEAD[idx_q];
      JOB_BLOCK: begin
        case (idx_q)
          IDX_W'(1): byte_sel = job_i.run[7:0];
          IDX_W'(2): byte_sel = job_i.run[15:8];
          IDX_W'(3): byte_sel = ~job_i.run[7:0];
          IDX_W'(4): byte_sel = ~job_i.run[15:8];
          IDX_W'(5): byte_sel = job_i.dbyte;
          default:   byte_sel = 8'd0;
        endcase
      end
      JOB_DATA: byte_sel = job_i.dbyte;
      JOB_FINISH: begin
        case (idx_q)
          IDX_W'(5):  byte_sel = job_i.crc[7:0];
          IDX_W'(6):  byte_sel = job_i.crc[15:8];
          IDX_W'(7):  byte_sel = job_i.crc[23:16];
          IDX_W'(8):  byte_sel = job_i.crc[31:24];
          IDX_W'(9):  byte_sel = job_i.total[7:0];
          IDX_W'(10): byte_sel = job_i.total[15:8];
          IDX_W'(11): byte_sel = job_i.total[23:16];
          IDX_W'(12): byte_sel = {1'b0, job_i.total[30:24]};
          default:    byte_sel = (idx_q < IDX_W'(5)) ? FINAL_BLOCK[idx_q[2:0]] : 8'd0;
        endcase
      end
      default: status_sel = job_i.status;
    endcase
  end

  // byte index within the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (load) begin
      idx_q <= is_last ? '0 : idx_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= byte_sel;
      out_status_q <= status_sel;
      out_last_q   <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  `ASSERT_IMPL(a_idx_needs_job, idx_q != '0, q_valid_i, "job left queue mid expansion")
  `ASSERT_IMPL(a_error_shape, out_valid_q && (out_status_q != ST_OK), out_last_q && (out_byte_q == 8'd0), "error item not single zero byte")
  `ASSERT_NEXT(a_pop_restarts, pop_o, idx_q == '0, "index not cleared after job")

endmodule

`default_nettype wire

// ===== dv/gzip_stored_block_framer_checker.sv =====
// ----------------------------------------------------------------------------
// gzip_stored_block_framer_checker
// Watches the command, result and register ports of the framer, works out
// the gzip bytes each accepted command should give and compares every
// accepted result with the oldest byte still owed, field by field.
// ----------------------------------------------------------------------------
module gzip_stored_block_framer_checker
  import gzf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       action_i,
  input  logic [LEN_W-1:0] chunk_length_i,
  input  logic [7:0]       data_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [7:0]       out_byte_i,
  input  logic [1:0]       status_i,
  input  logic             last_i,
  output int unsigned      n_errors_o,
  output int unsigned      n_pending_o,
  output int unsigned      n_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0]      CRC32_POLY   = 32'hedb8_8320;
  localparam logic [LEN_W-1:0] LIMIT_AT_RST = 31'h4000_0000;
  localparam logic [15:0]      LONGEST_RUN  = 16'hffff;
  localparam logic [79:0]      GZIP_HEADER  = {8'd31, 8'd139, 8'd8, 8'd0, 8'd0,
                                               8'd0, 8'd0, 8'd0, 8'd0, 8'd255};
  localparam logic [39:0]      EMPTY_FINAL  = {8'd1, 8'd0, 8'd0, 8'd255, 8'd255};

  typedef struct packed {
    logic [7:0] obyte;
    logic [1:0] status;
    logic       last;
  } gz_out_t;

  // bytes still owed by the framer, oldest first
  gz_out_t owed_bytes [$];

  // own copy of the framer state
  logic [LEN_W-1:0] limit_q;
  logic [31:0]      crc_q;
  logic [LEN_W-1:0] total_q;
  logic [LEN_W-1:0] chunk_left_q;
  logic [15:0]      block_left_q;
  bit               failed_q;
  bit               in_stream_q;

  // one step of the reflected crc-32
  function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void owe(input logic [7:0] b, input logic [1:0] st, input logic lst);
    owed_bytes.push_back('{obyte: b, status: st, last: lst});
  endfunction

  // sticky failure, one zero byte flagged with the error code
  function automatic void reject(input logic [1:0] code);
    failed_q = 1'b1;
    owe(8'd0, code, 1'b1);
  endfunction

  // gzip bytes caused by one command
  task automatic frame_command(input action_e act, input logic [LEN_W-1:0] len,
                               input logic [7:0] db);
    logic [15:0] run_len;
    logic [31:0] crc_out;
    logic [31:0] isize;
    if (failed_q) begin
      reject(ST_SEQ);
    end else begin
      case (act)
        ACT_START: begin
          if (in_stream_q) begin
            reject(ST_SEQ);
          end else begin
            crc_q        = '1;
            total_q      = '0;
            chunk_left_q = '0;
            block_left_q = '0;
            in_stream_q  = 1'b1;
            for (int i = 0; i < 10; i++) owe(GZIP_HEADER[79-8*i -: 8], ST_OK, i == 9);
          end
        end
        ACT_CHUNK: begin
          if (!in_stream_q || chunk_left_q != 0) begin
            reject(ST_SEQ);
          end else if (len > limit_q || total_q > limit_q - len) begin
            reject(ST_LIMIT);
          end else begin
            chunk_left_q = len;
            total_q      = total_q + len;
            block_left_q = '0;
          end
        end
        ACT_DATA: begin
          if (!in_stream_q || chunk_left_q == 0) begin
            reject(ST_SEQ);
          end else begin
            // stored-block header ahead of each run
            if (block_left_q == 0) begin
              run_len = (chunk_left_q > LONGEST_RUN) ? LONGEST_RUN : chunk_left_q[15:0];
              owe(8'd0, ST_OK, 1'b0);
              owe(run_len[7:0], ST_OK, 1'b0);
              owe(run_len[15:8], ST_OK, 1'b0);
              owe(~run_len[7:0], ST_OK, 1'b0);
              owe(~run_len[15:8], ST_OK, 1'b0);
              block_left_q = run_len;
            end
            owe(db, ST_OK, 1'b1);
            crc_q        = crc32_fold(crc_q, db);
            block_left_q = block_left_q - 1'b1;
            chunk_left_q = chunk_left_q - 1'b1;
          end
        end
        default: begin
          if (!in_stream_q || chunk_left_q != 0) begin
            reject(ST_SEQ);
          end else begin
            crc_out = ~crc_q;
            isize   = {1'b0, total_q};
            for (int i = 0; i < 5; i++) owe(EMPTY_FINAL[39-8*i -: 8], ST_OK, 1'b0);
            for (int i = 0; i < 4; i++) owe(crc_out[8*i +: 8], ST_OK, 1'b0);
            for (int i = 0; i < 4; i++) owe(isize[8*i +: 8], ST_OK, i == 3);
            in_stream_q = 1'b0;
          end
        end
      endcase
    end
  endtask

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      n_errors_o++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    gz_out_t want;
    if (!rst_ni) begin
      owed_bytes.delete();
      limit_q      = LIMIT_AT_RST;
      crc_q        = '1;
      total_q      = '0;
      chunk_left_q = '0;
      block_left_q = '0;
      failed_q     = 1'b0;
      in_stream_q  = 1'b0;
      n_errors_o   = 0;
      n_pending_o  = 0;
      n_checked_o  = 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      // results first, a byte never answers a command of the same edge
      if (out_valid_i && !out_stall_i) begin
        if (owed_bytes.size() == 0) begin
          n_errors_o++;
          $display("%0t: result expected none, got out_byte %0d status %0d last %0d",
                   $time, out_byte_i, status_i, last_i);
        end else begin
          want = owed_bytes.pop_front();
          n_checked_o++;
          compare_field("out_byte", 32'(want.obyte), 32'(out_byte_i));
          compare_field("status", 32'(want.status), 32'(status_i));
          compare_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        frame_command(action_e'(action_i), chunk_length_i, data_byte_i);
      n_pending_o = owed_bytes.size();
    end
  end

endmodule

// ===== dv/gzip_stored_block_framer_tb.sv =====
// ----------------------------------------------------------------------------
// gzip_stored_block_framer_tb
// Drives command items into the framer: a short directed part, one chunk sent
// with no idling while the receiver once holds off long enough to back the
// framer up, random well-formed streams under changing size limits, and a
// closing sticky error with noise behind it. Both sides idle at random
// elsewhere. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module gzip_stored_block_framer_tb;
  import gzf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [LEN_W-1:0] LIMIT_TOP    = 31'h4000_0000;
  localparam int unsigned      STEADY_CHUNK = 40;
  localparam int unsigned      HOLD_AT      = 10;
  localparam int unsigned      RANDOM_ITEMS = 170;
  localparam int unsigned      NOISE_ITEMS  = 15;
  localparam int unsigned      HOLD_CYCLES  = 400;
  localparam int unsigned      DRAIN_CYCLES = 20;
  localparam int unsigned      WATCHDOG     = 4000;

  // ways of breaking the command sequence at the end of the run
  typedef enum int {
    MISUSE_OVER_LIMIT,
    MISUSE_START_IN_STREAM,
    MISUSE_CHUNK_OUTSIDE,
    MISUSE_CHUNK_OWED,
    MISUSE_DATA_OUTSIDE,
    MISUSE_DATA_NONE_OWED,
    MISUSE_FINISH_OUTSIDE,
    MISUSE_FINISH_OWED
  } misuse_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       action_i;
  logic [LEN_W-1:0] chunk_length_i;
  logic [7:0]       data_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_byte_o;
  logic [1:0]       status_o;
  logic             last_o;

  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned n_checked;

  int unsigned      items_sent;
  int unsigned      streams_done;
  int unsigned      limit_writes;
  int unsigned      quiet_cycles;
  logic [LEN_W-1:0] cur_limit = LIMIT_TOP;
  bit               steady;
  bit               backlog_req;
  misuse_e          misuse;

  gzip_stored_block_framer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .chunk_length_i (chunk_length_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  gzip_stored_block_framer_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .action_i       (action_i),
    .chunk_length_i (chunk_length_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_i     (out_byte_o),
    .status_i       (status_o),
    .last_i         (last_o),
    .n_errors_o     (n_errors),
    .n_pending_o    (n_pending),
    .n_checked_o    (n_checked)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // progress watchdog, any accepted item or register write counts
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no progress for %0d cycles, %0d bytes still owed",
               $time, WATCHDOG, n_pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin : receiver
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < 19);
    end
  end

  function automatic logic [LEN_W-1:0] rand_len();
    return LEN_W'($urandom());
  endfunction

  // payload byte, extremes a little more often
  function automatic logic [7:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom());
  endfunction

  // offer one item, return once it is accepted
  task automatic send_item(input action_e act, input logic [LEN_W-1:0] len,
                           input logic [7:0] db);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    chunk_length_i <= len;
    data_byte_i    <= db;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // size limit writes only once every owed byte has come out
  task automatic write_limit(input logic [LEN_W-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  // well-formed stream with random chunks kept within the limit
  task automatic run_stream(input int unsigned max_chunks);
    int unsigned n_chunks;
    int unsigned room;
    int unsigned len;
    n_chunks = $urandom_range(0, max_chunks);
    room     = cur_limit;
    send_item(ACT_START, rand_len(), pick_payload());
    repeat (n_chunks) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
      if (len > room) len = room;
      room -= len;
      send_item(ACT_CHUNK, LEN_W'(len), pick_payload());
      repeat (len) send_item(ACT_DATA, rand_len(), pick_payload());
    end
    send_item(ACT_FINISH, rand_len(), pick_payload());
    streams_done++;
  endtask

  initial begin : stimulus
    int unsigned random_from;
    int unsigned r;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_START;
    chunk_length_i <= '0;
    data_byte_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest limit, filled exactly by one byte
    write_limit(31'd1);
    send_item(ACT_START, '0, 8'h00);
    send_item(ACT_CHUNK, 31'd1, 8'h00);
    send_item(ACT_DATA, '1, 8'hff);
    send_item(ACT_FINISH, '0, 8'h00);
    streams_done++;

    // zero-length chunks around one that fills a limit of three
    write_limit(31'd3);
    send_item(ACT_START, '1, 8'hff);
    send_item(ACT_CHUNK, 31'd0, 8'h00);
    send_item(ACT_CHUNK, 31'd3, 8'hff);
    send_item(ACT_DATA, '0, 8'h00);
    send_item(ACT_DATA, '0, 8'h80);
    send_item(ACT_DATA, '0, 8'h7f);
    send_item(ACT_CHUNK, 31'd0, 8'h00);
    send_item(ACT_FINISH, '1, 8'hff);
    streams_done++;

    // empty stream
    send_item(ACT_START, '0, 8'h00);
    send_item(ACT_FINISH, '0, 8'h00);
    streams_done++;

    // one chunk with no idling anywhere, the receiver holds off part way
    write_limit(LIMIT_TOP);
    steady = 1'b1;
    send_item(ACT_START, rand_len(), pick_payload());
    send_item(ACT_CHUNK, LEN_W'(STEADY_CHUNK), pick_payload());
    for (int unsigned i = 0; i < STEADY_CHUNK; i++) begin
      if (i == HOLD_AT) backlog_req = 1'b1;
      send_item(ACT_DATA, rand_len(), pick_payload());
    end
    send_item(ACT_FINISH, rand_len(), pick_payload());
    steady = 1'b0;
    streams_done++;

    // random streams under changing size limits
    random_from = items_sent;
    while (items_sent - random_from < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 25)      write_limit(31'd1);
        else if (r < 50) write_limit(LIMIT_TOP);
        else if (r < 75) write_limit(LEN_W'($urandom_range(1, 64)));
        else             write_limit(LEN_W'($urandom_range(1, LIMIT_TOP)));
      end
      run_stream(4);
    end

    // break the sequence once, everything after it must stay rejected
    misuse = misuse_e'($urandom_range(MISUSE_OVER_LIMIT, MISUSE_FINISH_OWED));
    case (misuse)
      MISUSE_OVER_LIMIT: begin
        send_item(ACT_START, rand_len(), pick_payload());
        send_item(ACT_CHUNK, '1, pick_payload());
      end
      MISUSE_START_IN_STREAM: begin
        send_item(ACT_START, rand_len(), pick_payload());
        send_item(ACT_START, rand_len(), pick_payload());
      end
      MISUSE_CHUNK_OUTSIDE: begin
        send_item(ACT_CHUNK, 31'd0, pick_payload());
      end
      MISUSE_CHUNK_OWED: begin
        send_item(ACT_START, rand_len(), pick_payload());
        send_item(ACT_CHUNK, 31'd1, pick_payload());
        send_item(ACT_CHUNK, 31'd0, pick_payload());
      end
      MISUSE_DATA_OUTSIDE: begin
        send_item(ACT_DATA, rand_len(), pick_payload());
      end
      MISUSE_DATA_NONE_OWED: begin
        send_item(ACT_START, rand_len(), pick_payload());
        send_item(ACT_CHUNK, 31'd1, pick_payload());
        send_item(ACT_DATA, rand_len(), pick_payload());
        send_item(ACT_DATA, rand_len(), pick_payload());
      end
      MISUSE_FINISH_OUTSIDE: begin
        send_item(ACT_FINISH, rand_len(), pick_payload());
      end
      default: begin
        send_item(ACT_START, rand_len(), pick_payload());
        send_item(ACT_CHUNK, 31'd1, pick_payload());
        send_item(ACT_FINISH, rand_len(), pick_payload());
      end
    endcase
    repeat (NOISE_ITEMS) send_item(action_e'($urandom_range(0, 3)), rand_len(), 8'($urandom()));

    // drain and settle
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d command items in %0d streams under %0d size limits",
             items_sent, streams_done, limit_writes);
    $display("%0d bytes checked, one %0d-cycle receiver hold-off; closing error: %s",
             n_checked, HOLD_CYCLES, misuse.name());
    if (n_errors == 0 && n_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d bytes never came", n_errors, n_pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== gzip_stored_block_framer.f =====
+incdir+design
design/gzf_pkg.sv
design/gzf_front.sv
design/gzf_queue.sv
design/gzf_back.sv
design/gzip_stored_block_framer.sv
dv/gzip_stored_block_framer_checker.sv
dv/gzip_stored_block_framer_tb.sv
